// ===== rtl/dtpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared constants and types for the depth-to-point back-projection block.
// ----------------------------------------------------------------------------
package dtpb_pkg;

  localparam int unsigned MAX_IMAGE_DIM = 4096;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned DepthW  = 32;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned PointW  = 48;
  localparam int unsigned ZW      = 32;
  localparam int unsigned CenterW = 16;
  localparam int unsigned InvW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // pipeline register stages
  localparam int unsigned NStages = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRINC_COL   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRINC_ROW   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INV_FOCAL_X = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INV_FOCAL_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_FMT   = 3'd4;

  localparam logic [CenterW-1:0] PRINC_COL_RST   = 16'd5120;
  localparam logic [CenterW-1:0] PRINC_ROW_RST   = 16'd3840;
  localparam logic [InvW-1:0]    INV_FOCAL_RST   = 32'd8589935;

  localparam logic FMT_MM    = 1'b0;
  localparam logic FMT_FLOAT = 1'b1;

  // mm -> Q16.16 metres: (mm*65536 + 500) / 1000 = ((..) >> 3) / 125
  localparam logic [31:0] MM_ROUND   = 32'd500;
  localparam logic [30:0] RECIP_125  = 31'd1099511627;  // floor(2^37 / 125)
  localparam int unsigned RecipShift = 37;
  localparam logic [28:0] DIV_125    = 29'd125;

  // float exponent at which the mantissa lands on Q16.16 unshifted
  localparam logic [7:0]  FLT_EXP_Q16 = 8'd134;
  localparam logic [7:0]  FLT_EXP_SAT = 8'd143;
  localparam logic [7:0]  FLT_EXP_MAX = 8'hFF;

  localparam logic [PointW-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [PointW-1:0] NEG_MAG = 48'h8000_0000_0000;

  typedef struct packed {
    logic              has_color;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              last;
  } side_t;

  typedef struct packed {
    logic               neg_x;
    logic [15:0]        mag_x;
    logic               neg_y;
    logic [15:0]        mag_y;
  } offs_t;

endpackage

// ===== rtl/depth_to_point_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_to_point_backprojection
// Pinhole back-projection of a depth pixel stream into 3D points.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one pixel word (column, row,
// raw depth, colour, frame-end flag); a word is taken when valid is high and
// stall is low. Output channel: out_valid_o / out_stall_i carry one point
// word per pixel, in order. The configuration channel (cfg_valid_i,
// cfg_ready_o, cfg_index_i, cfg_data_i) is always ready; write it only while
// the pipeline is empty.
// Throughput is one word per cycle while out_stall_i is low. The rate is set
// by the six-stage pipeline: depth decode, reciprocal multiply for the mm
// divide, divide correction, offset times depth, times inverse focal length,
// then round and saturate.
// Reset clears all stage valid bits and loads the default camera intrinsics
// with millimetre depth. When the receiver stalls, the output word holds and
// the stall backs up stage by stage; bubbles are squeezed out first, so
// in_stall_o rises only when every stage is full.
module depth_to_point_backprojection
  import dtpb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDatW-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CoordW-1:0]        column_i,
  input  logic [CoordW-1:0]        row_i,
  input  logic [DepthW-1:0]        depth_raw_i,
  input  logic                     pixel_has_color_i,
  input  logic [ColorW-1:0]        pixel_red_i,
  input  logic [ColorW-1:0]        pixel_green_i,
  input  logic [ColorW-1:0]        pixel_blue_i,
  input  logic                     last_pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [PointW-1:0] point_x_o,
  output logic signed [PointW-1:0] point_y_o,
  output logic [ZW-1:0]            point_z_o,
  output logic                     point_valid_o,
  output logic                     point_has_color_o,
  output logic [ColorW-1:0]        point_red_o,
  output logic [ColorW-1:0]        point_green_o,
  output logic [ColorW-1:0]        point_blue_o,
  output logic                     frame_end_o
);

  // ---------------- configuration ----------------
  logic [CenterW-1:0] princ_col_q, princ_row_q;
  logic [InvW-1:0]    inv_fx_q, inv_fy_q;
  logic               fmt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      princ_col_q <= PRINC_COL_RST;
      princ_row_q <= PRINC_ROW_RST;
      inv_fx_q    <= INV_FOCAL_RST;
      inv_fy_q    <= INV_FOCAL_RST;
      fmt_q       <= FMT_MM;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRINC_COL:   princ_col_q <= cfg_data_i[CenterW-1:0];
        CFG_PRINC_ROW:   princ_row_q <= cfg_data_i[CenterW-1:0];
        CFG_INV_FOCAL_X: inv_fx_q    <= cfg_data_i;
        CFG_INV_FOCAL_Y: inv_fy_q    <= cfg_data_i;
        CFG_DEPTH_FMT:   fmt_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NStages-1:0] v_q;
  logic [NStages-1:0] adv;

  always_comb begin
    adv[NStages-1] = !v_q[NStages-1] || !out_stall_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage A: depth decode, pixel offsets ----------------
  logic [ZW-1:0] fz_d;
  logic          fok_d;
  logic [28:0]   n_d;
  logic          mmok_d;
  logic          coord_ok_d;
  offs_t         offs_d;

  always_comb begin
    logic [7:0]  expo;
    logic [7:0]  e_eff;
    logic [23:0] mant;
    logic [7:0]  rsh;
    logic [24:0] rsum;
    logic [31:0] num;
    logic [16:0] dx, dy;
    expo  = depth_raw_i[30:23];
    mant  = (expo == 8'd0) ? {1'b0, depth_raw_i[22:0]} : {1'b1, depth_raw_i[22:0]};
    e_eff = (expo == 8'd0) ? 8'd1 : expo;
    fok_d = (expo != FLT_EXP_MAX) && !depth_raw_i[31] && (depth_raw_i[30:0] != 31'd0);
    rsh   = FLT_EXP_Q16 - e_eff;
    rsum  = '0;
    if (e_eff >= FLT_EXP_SAT) begin
      fz_d = '1;
    end else if (e_eff >= FLT_EXP_Q16) begin
      fz_d = {8'd0, mant} << (e_eff - FLT_EXP_Q16);
    end else if (rsh > 8'd25) begin
      fz_d = '0;
    end else begin
      // round to nearest, ties upward
      rsum = {1'b0, mant} + (25'd1 << (rsh[4:0] - 5'd1));
      fz_d = {7'd0, rsum >> rsh[4:0]};
    end

    num    = {depth_raw_i[15:0], 16'd0} + MM_ROUND;
    n_d    = num[31:3];
    mmok_d = depth_raw_i[15:0] != 16'd0;

    coord_ok_d = ({1'b0, column_i} < 13'(MAX_IMAGE_DIM)) &&
                 ({1'b0, row_i} < 13'(MAX_IMAGE_DIM));

    dx = {1'b0, column_i, 4'd0} - {1'b0, princ_col_q};
    dy = {1'b0, row_i, 4'd0} - {1'b0, princ_row_q};
    offs_d.neg_x = dx[16];
    offs_d.mag_x = dx[16] ? 16'(-dx) : dx[15:0];
    offs_d.neg_y = dy[16];
    offs_d.mag_y = dy[16] ? 16'(-dy) : dy[15:0];
  end

  logic [ZW-1:0] a_fz_q;
  logic [28:0]   a_n_q;
  logic          a_ok_q, a_fmt_q;
  offs_t         a_offs_q;
  side_t         a_side_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_fz_q   <= fz_d;
      a_n_q    <= n_d;
      a_fmt_q  <= fmt_q;
      a_ok_q   <= coord_ok_d && ((fmt_q == FMT_FLOAT) ? fok_d : mmok_d);
      a_offs_q <= offs_d;
      a_side_q <= '{has_color: pixel_has_color_i, red: pixel_red_i,
                    green: pixel_green_i, blue: pixel_blue_i, last: last_pixel_i};
    end
  end

  // ---------------- stage B: reciprocal estimate of n / 125 ----------------
  logic [59:0] recip_prod;
  assign recip_prod = {31'd0, a_n_q} * {29'd0, RECIP_125};

  logic [22:0]   b_q0_q;
  logic [28:0]   b_n_q;
  logic [ZW-1:0] b_fz_q;
  logic          b_ok_q, b_fmt_q;
  offs_t         b_offs_q;
  side_t         b_side_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      b_q0_q   <= recip_prod[RecipShift+22:RecipShift];
      b_n_q    <= a_n_q;
      b_fz_q   <= a_fz_q;
      b_ok_q   <= a_ok_q;
      b_fmt_q  <= a_fmt_q;
      b_offs_q <= a_offs_q;
      b_side_q <= a_side_q;
    end
  end

  // ---------------- stage C: quotient correction, depth select ----------------
  logic [28:0]   rem;
  logic [22:0]   q_mm;
  logic [ZW-1:0] z_sel;

  always_comb begin
    // estimate is low by at most one
    rem   = b_n_q - {6'd0, b_q0_q} * DIV_125;
    q_mm  = (rem >= DIV_125) ? b_q0_q + 23'd1 : b_q0_q;
    z_sel = (b_fmt_q == FMT_FLOAT) ? b_fz_q : {9'd0, q_mm};
  end

  logic [ZW-1:0] c_z_q;
  logic          c_ok_q;
  offs_t         c_offs_q;
  side_t         c_side_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      c_z_q    <= b_ok_q ? z_sel : '0;
      c_ok_q   <= b_ok_q;
      c_offs_q <= b_offs_q;
      c_side_q <= b_side_q;
    end
  end

  // ---------------- stage D: |offset| * z ----------------
  logic [47:0]   d_px_q, d_py_q;
  logic [ZW-1:0] d_z_q;
  logic          d_ok_q, d_negx_q, d_negy_q;
  side_t         d_side_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      d_px_q   <= {32'd0, c_offs_q.mag_x} * {16'd0, c_z_q};
      d_py_q   <= {32'd0, c_offs_q.mag_y} * {16'd0, c_z_q};
      d_negx_q <= c_offs_q.neg_x;
      d_negy_q <= c_offs_q.neg_y;
      d_z_q    <= c_z_q;
      d_ok_q   <= c_ok_q;
      d_side_q <= c_side_q;
    end
  end

  // ---------------- stage E: times inverse focal length ----------------
  logic [63:0] lo_x_prod, lo_y_prod;
  assign lo_x_prod = {32'd0, d_px_q[31:0]} * {32'd0, inv_fx_q};
  assign lo_y_prod = {32'd0, d_py_q[31:0]} * {32'd0, inv_fy_q};

  logic [47:0]   e_hix_q, e_hiy_q;
  logic [31:0]   e_lox_q, e_loy_q;
  logic [ZW-1:0] e_z_q;
  logic          e_ok_q, e_negx_q, e_negy_q;
  side_t         e_side_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      e_hix_q  <= {32'd0, d_px_q[47:32]} * {16'd0, inv_fx_q};
      e_hiy_q  <= {32'd0, d_py_q[47:32]} * {16'd0, inv_fy_q};
      e_lox_q  <= lo_x_prod[63:32];
      e_loy_q  <= lo_y_prod[63:32];
      e_negx_q <= d_negx_q;
      e_negy_q <= d_negy_q;
      e_z_q    <= d_z_q;
      e_ok_q   <= d_ok_q;
      e_side_q <= d_side_q;
    end
  end

  // ---------------- stage F: round, sign, saturate ----------------
  function automatic logic [PointW-1:0] finish(logic [47:0] hi, logic [31:0] lo, logic neg);
    logic [48:0]       sum;
    logic [PointW-1:0] res;
    sum = {1'b0, hi} + {17'd0, lo} + 49'd8;
    res = {3'd0, sum[48:4]};
    if (neg) begin
      if (res > NEG_MAG) res = NEG_MAG;
      finish = PointW'(-res);
    end else begin
      finish = (res > POS_MAX) ? POS_MAX : res;
    end
  endfunction

  logic color_en;
  assign color_en = e_ok_q && e_side_q.has_color;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      point_x_o         <= e_ok_q ? finish(e_hix_q, e_lox_q, e_negx_q) : '0;
      point_y_o         <= e_ok_q ? finish(e_hiy_q, e_loy_q, e_negy_q) : '0;
      point_z_o         <= e_ok_q ? e_z_q : '0;
      point_valid_o     <= e_ok_q;
      point_has_color_o <= color_en;
      point_red_o       <= color_en ? e_side_q.red : '0;
      point_green_o     <= color_en ? e_side_q.green : '0;
      point_blue_o      <= color_en ? e_side_q.blue : '0;
      frame_end_o       <= e_side_q.last;
    end
  end

endmodule

// ===== tb/dtpb_point_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtpb_point_checker
// Watches the register, pixel and point channels of the back-projection block.
// For every pixel word taken it computes the expected point word and queues it.
// Each point word that leaves the block is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module dtpb_point_checker
  import dtpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [CoordW-1:0]  column_i,
  input  logic [CoordW-1:0]  row_i,
  input  logic [DepthW-1:0]  depth_raw_i,
  input  logic               pixel_has_color_i,
  input  logic [ColorW-1:0]  pixel_red_i,
  input  logic [ColorW-1:0]  pixel_green_i,
  input  logic [ColorW-1:0]  pixel_blue_i,
  input  logic               last_pixel_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [PointW-1:0]  point_x_i,
  input  logic [PointW-1:0]  point_y_i,
  input  logic [ZW-1:0]      point_z_i,
  input  logic               point_valid_i,
  input  logic               point_has_color_i,
  input  logic [ColorW-1:0]  point_red_i,
  input  logic [ColorW-1:0]  point_green_i,
  input  logic [ColorW-1:0]  point_blue_i,
  input  logic               frame_end_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [PointW-1:0] x;
    logic [PointW-1:0] y;
    logic [ZW-1:0]     z;
    logic              valid;
    logic              has_color;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              frame_end;
  } point_t;

  // float exponent at which the 24-bit mantissa is already Q16.16
  localparam int FloatQ16Exp = 127 + 23 - 16;

  logic [CenterW-1:0] princ_col;
  logic [CenterW-1:0] princ_row;
  logic [InvW-1:0]    inv_fx;
  logic [InvW-1:0]    inv_fy;
  logic               depth_fmt;
  point_t             points_due[$];
  int                 fails;

  function automatic logic [ZW-1:0] mm_to_fix(input logic [15:0] mm);
    logic [63:0] num;
    num = 64'(mm);
    num = ((num << 16) + 64'd500) / 64'd1000;
    return num[ZW-1:0];
  endfunction

  // {valid, z}: non-finite, signed or zero depth is invalid
  function automatic logic [ZW:0] float_to_fix(input logic [31:0] bits);
    logic [7:0]  expo;
    logic [63:0] mant;
    logic [63:0] v;
    int          sh;
    expo = bits[30:23];
    if (expo == 8'hFF || bits[31] || bits[30:0] == 31'd0) return {1'b0, 32'd0};
    if (expo == 8'd0) begin
      mant = 64'(bits[22:0]);
      expo = 8'd1;
    end else begin
      mant = 64'({1'b1, bits[22:0]});
    end
    sh = int'(expo) - FloatQ16Exp;
    if (sh >= 9) return {1'b1, 32'hFFFF_FFFF};
    if (sh >= 0) begin
      v = mant << sh;
      return {1'b1, (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0]};
    end
    if (-sh > 25) return {1'b1, 32'd0};
    v = (mant + (64'd1 << (-sh - 1))) >> (-sh);
    return {1'b1, v[31:0]};
  endfunction

  // (16*coord - center) * z * inv, Q.52 rounded half away to Q.16, saturated
  function automatic logic [PointW-1:0] project_axis(input logic [CoordW-1:0]  coord,
                                                      input logic [CenterW-1:0] center,
                                                      input logic [ZW-1:0]      z,
                                                      input logic [InvW-1:0]    inv);
    logic signed [19:0] d;
    logic [19:0]        mag;
    logic [95:0]        prod;
    logic               neg;
    d    = $signed({4'd0, coord, 4'd0}) - $signed({4'd0, center});
    neg  = d < 0;
    mag  = neg ? -d : d;
    prod = 96'(mag);
    prod = prod * 96'(z);
    prod = prod * 96'(inv);
    prod = (prod + 96'h8_0000_0000) >> 36;
    if (neg) begin
      if (prod > 96'(NEG_MAG)) prod = 96'(NEG_MAG);
      return -prod[PointW-1:0];
    end
    if (prod > 96'(POS_MAX)) prod = 96'(POS_MAX);
    return prod[PointW-1:0];
  endfunction

  function automatic point_t backproject_pixel(input logic [CoordW-1:0] col,
                                               input logic [CoordW-1:0] row,
                                               input logic [DepthW-1:0] raw,
                                               input logic              has_color,
                                               input logic [ColorW-1:0] red,
                                               input logic [ColorW-1:0] green,
                                               input logic [ColorW-1:0] blue,
                                               input logic              last);
    point_t      pt;
    logic [ZW:0] dec;
    pt = '0;
    if (depth_fmt == FMT_FLOAT) dec = float_to_fix(raw);
    else if (raw[15:0] != 16'd0) dec = {1'b1, mm_to_fix(raw[15:0])};
    else dec = '0;
    if (dec[ZW]) begin
      pt.x     = project_axis(col, princ_col, dec[ZW-1:0], inv_fx);
      pt.y     = project_axis(row, princ_row, dec[ZW-1:0], inv_fy);
      pt.z     = dec[ZW-1:0];
      pt.valid = 1'b1;
      if (has_color) begin
        pt.has_color = 1'b1;
        pt.red       = red;
        pt.green     = green;
        pt.blue      = blue;
      end
    end
    pt.frame_end = last;
    return pt;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    point_t due;
    if (!rst_ni) begin
      princ_col = PRINC_COL_RST;
      princ_row = PRINC_ROW_RST;
      inv_fx    = INV_FOCAL_RST;
      inv_fy    = INV_FOCAL_RST;
      depth_fmt = FMT_MM;
      points_due.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PRINC_COL:   princ_col = cfg_data_i[CenterW-1:0];
          CFG_PRINC_ROW:   princ_row = cfg_data_i[CenterW-1:0];
          CFG_INV_FOCAL_X: inv_fx    = cfg_data_i[InvW-1:0];
          CFG_INV_FOCAL_Y: inv_fy    = cfg_data_i[InvW-1:0];
          CFG_DEPTH_FMT:   depth_fmt = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        points_due.push_back(backproject_pixel(column_i, row_i, depth_raw_i,
                                               pixel_has_color_i, pixel_red_i,
                                               pixel_green_i, pixel_blue_i,
                                               last_pixel_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (points_due.size() == 0) begin
          fails++;
          $display("%0t unexpected point word: expected none, got x=%h y=%h z=%h",
                   $time, point_x_i, point_y_i, point_z_i);
        end else begin
          due = points_due.pop_front();
          check_field("point_x", due.x, point_x_i);
          check_field("point_y", due.y, point_y_i);
          check_field("point_z", due.z, point_z_i);
          check_field("point_valid", due.valid, point_valid_i);
          check_field("point_has_color", due.has_color, point_has_color_i);
          check_field("point_red", due.red, point_red_i);
          check_field("point_green", due.green, point_green_i);
          check_field("point_blue", due.blue, point_blue_i);
          check_field("frame_end", due.frame_end, frame_end_i);
        end
      end
    end
    pending_o    <= points_due.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for depth_to_point_backprojection.
// Directed depth edge cases in both formats, then random pixel streams under
// several camera settings, with random gaps on both channels, quiet stretches
// and one long output hold-off that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb;
  import dtpb_pkg::*;

  localparam int LimitCycles = 1_000_000;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 200;
  localparam int Phases      = 8;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDatW-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [CoordW-1:0]  column;
  logic [CoordW-1:0]  row;
  logic [DepthW-1:0]  depth_raw;
  logic               pixel_has_color;
  logic [ColorW-1:0]  pixel_red;
  logic [ColorW-1:0]  pixel_green;
  logic [ColorW-1:0]  pixel_blue;
  logic               last_pixel;
  logic               out_valid;
  logic               out_stall;
  logic signed [PointW-1:0] point_x;
  logic signed [PointW-1:0] point_y;
  logic [ZW-1:0]      point_z;
  logic               point_valid;
  logic               point_has_color;
  logic [ColorW-1:0]  point_red;
  logic [ColorW-1:0]  point_green;
  logic [ColorW-1:0]  point_blue;
  logic               frame_end;

  int   pending;
  int   fail_count;
  logic tx_noisy;
  logic rx_noisy;
  logic hold_req;
  logic cur_fmt;

  depth_to_point_backprojection dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .column_i          (column),
    .row_i             (row),
    .depth_raw_i       (depth_raw),
    .pixel_has_color_i (pixel_has_color),
    .pixel_red_i       (pixel_red),
    .pixel_green_i     (pixel_green),
    .pixel_blue_i      (pixel_blue),
    .last_pixel_i      (last_pixel),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .point_x_o         (point_x),
    .point_y_o         (point_y),
    .point_z_o         (point_z),
    .point_valid_o     (point_valid),
    .point_has_color_o (point_has_color),
    .point_red_o       (point_red),
    .point_green_o     (point_green),
    .point_blue_o      (point_blue),
    .frame_end_o       (frame_end)
  );

  dtpb_point_checker point_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .column_i          (column),
    .row_i             (row),
    .depth_raw_i       (depth_raw),
    .pixel_has_color_i (pixel_has_color),
    .pixel_red_i       (pixel_red),
    .pixel_green_i     (pixel_green),
    .pixel_blue_i      (pixel_blue),
    .last_pixel_i      (last_pixel),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .point_x_i         (point_x),
    .point_y_i         (point_y),
    .point_z_i         (point_z),
    .point_valid_i     (point_valid),
    .point_has_color_i (point_has_color),
    .point_red_i       (point_red),
    .point_green_i     (point_green),
    .point_blue_i      (point_blue),
    .frame_end_i       (frame_end),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high after the word is taken unless a gap follows
  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] rw,
                            input logic [DepthW-1:0] depth, input logic has_color,
                            input logic [ColorW-1:0] red, input logic [ColorW-1:0] green,
                            input logic [ColorW-1:0] blue, input logic last);
    int gap;
    in_valid        <= 1'b1;
    column          <= col;
    row             <= rw;
    depth_raw       <= depth;
    pixel_has_color <= has_color;
    pixel_red       <= red;
    pixel_green     <= green;
    pixel_blue      <= blue;
    last_pixel      <= last;
    do @(posedge clk); while (in_stall);
    gap = tx_noisy ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_pixel();
    logic [31:0] bits;
    logic [31:0] depth;
    logic [7:0]  ex;
    logic [15:0] mm_small;
    int          pick;
    bits     = $urandom();
    pick     = $urandom_range(0, 99);
    ex       = 8'($urandom_range(112, 142));
    mm_small = 16'($urandom_range(1, 200));
    if (cur_fmt == FMT_FLOAT) begin
      if (pick < 70) depth = {1'b0, ex, bits[22:0]};
      else if (pick < 78) depth = bits;
      else if (pick < 84) depth = {9'd0, bits[22:0]};
      else if (pick < 88) depth = {bits[31], 31'd0};
      else if (pick < 92) depth = {bits[31], 8'hFF, bits[0] ? 23'd0 : bits[22:0]};
      else if (pick < 96) depth = {1'b1, bits[30:0]};
      else begin
        ex    = 8'($urandom_range(143, 254));
        depth = {1'b0, ex, bits[22:0]};
      end
    end else begin
      if (pick < 10) depth = {bits[31:16], 16'd0};
      else if (pick < 25) depth = {bits[31:16], mm_small};
      else depth = bits;
    end
    send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), depth,
               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               $urandom_range(0, 19) == 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused upper data bits carry junk; the block must drop them
  task automatic program_camera(input logic [CenterW-1:0] cx, input logic [CenterW-1:0] cy,
                                input logic [InvW-1:0] ifx, input logic [InvW-1:0] ify,
                                input logic fmt);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(CFG_PRINC_COL, {junk[31:16], cx});
    cfg_write(CFG_PRINC_ROW, {junk[15:0], cy});
    cfg_write(CFG_INV_FOCAL_X, ifx);
    cfg_write(CFG_INV_FOCAL_Y, ify);
    cfg_write(CFG_DEPTH_FMT, {junk[30:0], fmt});
    cfg_valid <= 1'b0;
    cur_fmt = fmt;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin : receiver
    int run;
    out_stall = 1'b0;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        run = 0;
      end else if (!rx_noisy) begin
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        out_stall <= ~out_stall;
        run = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]        float_edges [0:13];
    logic [CenterW-1:0] cx;
    logic [CenterW-1:0] cy;
    logic [InvW-1:0]    ifx;
    logic [InvW-1:0]    ify;
    logic               fmt;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    column          = '0;
    row             = '0;
    depth_raw       = '0;
    pixel_has_color = 1'b0;
    pixel_red       = '0;
    pixel_green     = '0;
    pixel_blue      = '0;
    last_pixel      = 1'b0;
    tx_noisy        = 1'b1;
    rx_noisy        = 1'b1;
    hold_req        = 1'b0;
    cur_fmt         = FMT_MM;
    // +0, -0, +inf, -inf, NaN, -1.0, smallest subnormal, largest subnormal,
    // 2^-18 (rounds to zero), 2^-17 (tie rounds up), 1.0, just under and at
    // 65536.0, largest finite
    float_edges = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                    32'h7FC0_0001, 32'hBF80_0000, 32'h0000_0001, 32'h007F_FFFF,
                    32'h3680_0000, 32'h3700_0000, 32'h3F80_0000, 32'h477F_FFFF,
                    32'h4780_0000, 32'h7F7F_FFFF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // millimetre depth with reset intrinsics
    send_pixel(12'd0, 12'd0, 32'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(12'd0, 12'd0, 32'd1, 1'b1, 8'hFF, 8'h00, 8'hAA, 1'b0);
    send_pixel(12'd4095, 12'd4095, 32'h0000_FFFF, 1'b0, 8'h12, 8'h34, 8'h56, 1'b0);
    send_pixel(12'd320, 12'd240, 32'd1000, 1'b1, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(12'd100, 12'd4000, 32'hFFFF_0000, 1'b1, 8'h55, 8'h66, 8'h77, 1'b0);
    send_pixel(12'd4095, 12'd0, 32'hABCD_1234, 1'b1, 8'h80, 8'h01, 8'hFE, 1'b1);
    in_valid <= 1'b0;
    drain();

    program_camera(PRINC_COL_RST, PRINC_ROW_RST, INV_FOCAL_RST, INV_FOCAL_RST, FMT_FLOAT);
    for (int i = 0; i < 14; i++) begin
      send_pixel(i[0] ? 12'd4095 : 12'd0, i[1] ? 12'd4095 : 12'd0, float_edges[i],
                 1'b1, 8'hFF, 8'h00, 8'h5A, i == 13);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < Phases; p++) begin
      drain();
      if (p == 0) begin
        cx = '0; cy = '0; ifx = '0; ify = '0; fmt = FMT_MM;
      end else if (p == 1) begin
        cx = '1; cy = '1; ifx = '1; ify = '1; fmt = FMT_FLOAT;
      end else if (p < 4) begin
        cx  = PRINC_COL_RST;
        cy  = PRINC_ROW_RST;
        ifx = INV_FOCAL_RST;
        ify = INV_FOCAL_RST;
        fmt = (p == 3) ? FMT_FLOAT : FMT_MM;
      end else begin
        cx  = 16'($urandom_range(0, 65535));
        cy  = 16'($urandom_range(0, 65535));
        ifx = $urandom_range(0, 1) ? $urandom_range(2_000_000, 20_000_000) : $urandom();
        ify = $urandom_range(0, 1) ? $urandom_range(2_000_000, 20_000_000) : $urandom();
        fmt = p[0] ? FMT_FLOAT : FMT_MM;
      end
      program_camera(cx, cy, ifx, ify, fmt);
      tx_noisy = (p % 3 != 0) && (p != 4);
      rx_noisy = (p % 3 != 0);
      // long output hold-off while words keep coming: the pipeline fills up
      if (p == 4) hold_req = 1'b1;
      repeat (PhaseItems) send_random_pixel();
      in_valid <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
